// ===== rtl/qstp_pkg.sv =====
// Package for the smallest-three quaternion packer.
// Holds the shared types and fixed constants; depends on nothing.
`default_nettype none
package qstp_pkg;

  localparam int unsigned NUM_COMPS = 4;
  localparam int unsigned NUM_KEPT  = 3;
  localparam int unsigned CODE_BITS = 15;

  localparam logic [31:0] SCALE_Q16   = 32'd1518407568;
  localparam logic [16:0] CODE_OFFSET = 17'd16383;
  localparam logic [16:0] CODE_MAX    = 17'd32767;
  localparam logic [15:0] ZERO_WORD01 = 16'hBFFF;
  localparam logic [15:0] ZERO_WORD2  = 16'h3FFF;

  // Classification that travels alongside the magnitudes.
  typedef struct packed {
    logic [2:0] neg;
    logic [1:0] big_idx;
    logic       big_neg;
    logic       zero;
  } side_t;

  // Queue entry: mag[0..2] are the kept components in order, mag[3] the largest.
  typedef struct packed {
    logic [3:0][31:0] mag;
    side_t            side;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/qstp_front.sv =====
// Front part: takes requests, forms magnitudes and finds the largest component.
// Depends on qstp_pkg.
`default_nettype none
module qstp_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [31:0]        comp_x_i,
  input  wire logic [31:0]        comp_y_i,
  input  wire logic [31:0]        comp_z_i,
  input  wire logic [31:0]        comp_w_i,
  input  wire logic               full_i,
  output logic                    busy_o,
  output logic                    push_o,
  output qstp_pkg::entry_t        entry_o
);

  logic             valid_q, valid_d;
  logic [3:0][31:0] mag_q;
  logic [3:0]       neg_q;
  logic [3:0][31:0] comp;
  logic             accept;

  assign comp   = {comp_w_i, comp_z_i, comp_y_i, comp_x_i};
  assign busy_o = valid_q && full_i;
  assign accept = start_i && !busy_o;
  assign push_o = valid_q && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (push_o) valid_d = 1'b0;
    if (accept) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Two's complement magnitude; the most negative value gives 2^31, which fits.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        neg_q[i] <= comp[i][31];
        mag_q[i] <= comp[i][31] ? (~comp[i] + 32'd1) : comp[i];
      end
    end
  end

  always_comb begin
    logic [1:0] idx;
    logic [1:0] n;
    idx = 2'd0;
    n   = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (mag_q[i] > mag_q[idx]) idx = 2'(i);
    end
    entry_o = '0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) != idx) begin
        entry_o.mag[n]      = mag_q[i];
        entry_o.side.neg[n] = neg_q[i];
        n = n + 2'd1;
      end
    end
    entry_o.mag[3]       = mag_q[idx];
    entry_o.side.big_idx = idx;
    entry_o.side.big_neg = neg_q[idx];
    entry_o.side.zero    = (mag_q == '0);
  end

endmodule
`default_nettype wire

// ===== rtl/qstp_fifo.sv =====
// Two-entry queue between the front and back parts.
// Depends on qstp_pkg.
`default_nettype none
module qstp_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  qstp_pkg::entry_t entry_i,
  output logic             full_o,
  output logic             pop_o,
  output qstp_pkg::entry_t entry_o
);

  qstp_pkg::entry_t mem_q [2];
  logic [1:0]       count_q, count_d;
  logic             wr_q, rd_q;

  assign full_o  = (count_q == 2'd2);
  assign pop_o   = (count_q != 2'd0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_o})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_q <= ~wr_q;
      if (pop_o)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule
`default_nettype wire

// ===== rtl/qstp_back.sv =====
// Back part: squares, scaling products and a bit-per-stage root search.
// Depends on qstp_pkg.
`default_nettype none
module qstp_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pop_i,
  input  qstp_pkg::entry_t entry_i,
  output logic             valid_o,
  output logic [15:0]      packed_word0_o,
  output logic [15:0]      packed_word1_o,
  output logic [15:0]      packed_word2_o
);

  localparam int NB = int'(qstp_pkg::CODE_BITS);

  // Stage 1: squares of all four and a*K for the kept three.
  logic                s1_v_q;
  qstp_pkg::side_t     s1_sd_q;
  logic [63:0]         s1_sq_q [4];
  logic [62:0]         s1_t_q  [3];
  // Stage 2: squared length and partial products of (a*K)^2.
  logic                s2_v_q;
  qstp_pkg::side_t     s2_sd_q;
  logic [64:0]         s2_q_q;
  logic [61:0]         s2_hh_q [3];
  logic [62:0]         s2_hl_q [3];
  logic [63:0]         s2_ll_q [3];
  // Search stages: index 0 is the start, index k+1 follows bit 14-k.
  logic                v_q  [NB+1];
  qstp_pkg::side_t     sd_q [NB+1];
  logic [64:0]         q_q  [NB+1];
  logic [125:0]        r_q  [NB+1][3];
  logic [79:0]         p_q  [NB+1][3];
  logic [NB-1:0]       m_q  [NB+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      for (int k = 0; k <= NB; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      s1_v_q <= pop_i;
      s2_v_q <= s1_v_q;
      v_q[0] <= s2_v_q;
      for (int k = 0; k < NB; k++) begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  // Trying bit b on m: the extra term (2^(b+1) m + 2^(2b)) Q 2^32 comes from P = m*Q.
  always_ff @(posedge clk_i) begin
    logic [129:0] d;
    int           b;
    s1_sd_q <= entry_i.side;
    for (int i = 0; i < 4; i++) begin
      s1_sq_q[i] <= 64'(entry_i.mag[i]) * 64'(entry_i.mag[i]);
    end
    for (int j = 0; j < 3; j++) begin
      s1_t_q[j] <= 63'(entry_i.mag[j]) * 63'(qstp_pkg::SCALE_Q16);
    end

    s2_sd_q <= s1_sd_q;
    s2_q_q  <= 65'(s1_sq_q[0]) + 65'(s1_sq_q[1]) + 65'(s1_sq_q[2]) + 65'(s1_sq_q[3]);
    for (int j = 0; j < 3; j++) begin
      s2_hh_q[j] <= 62'(s1_t_q[j][62:32]) * 62'(s1_t_q[j][62:32]);
      s2_hl_q[j] <= 63'(s1_t_q[j][62:32]) * 63'(s1_t_q[j][31:0]);
      s2_ll_q[j] <= 64'(s1_t_q[j][31:0]) * 64'(s1_t_q[j][31:0]);
    end

    sd_q[0] <= s2_sd_q;
    q_q[0]  <= s2_q_q;
    for (int j = 0; j < 3; j++) begin
      r_q[0][j] <= (126'(s2_hh_q[j]) << 64) + (126'(s2_hl_q[j]) << 33) + 126'(s2_ll_q[j]);
      p_q[0][j] <= '0;
      m_q[0][j] <= '0;
    end

    for (int k = 0; k < NB; k++) begin
      b = NB - 1 - k;
      sd_q[k+1] <= sd_q[k];
      q_q[k+1]  <= q_q[k];
      for (int j = 0; j < 3; j++) begin
        d = ((130'(p_q[k][j]) << (b + 1)) + (130'(q_q[k]) << (2 * b))) << 32;
        if (d <= 130'(r_q[k][j])) begin
          r_q[k+1][j] <= r_q[k][j] - d[125:0];
          p_q[k+1][j] <= p_q[k][j] + (80'(q_q[k]) << b);
          m_q[k+1][j] <= m_q[k][j] | (NB'(1) << b);
        end else begin
          r_q[k+1][j] <= r_q[k][j];
          p_q[k+1][j] <= p_q[k][j];
          m_q[k+1][j] <= m_q[k][j];
        end
      end
    end
  end

  logic [NB-1:0] code [3];

  always_comb begin
    logic signed [17:0] c;
    for (int j = 0; j < 3; j++) begin
      if (sd_q[NB].neg[j]) begin
        c = signed'({1'b0, qstp_pkg::CODE_OFFSET}) - signed'(18'(m_q[NB][j]));
      end else begin
        c = signed'({1'b0, qstp_pkg::CODE_OFFSET}) + signed'(18'(m_q[NB][j]));
      end
      if (c < 0) begin
        code[j] = '0;
      end else if (c > signed'({1'b0, qstp_pkg::CODE_MAX})) begin
        code[j] = NB'(qstp_pkg::CODE_MAX);
      end else begin
        code[j] = c[NB-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v_q[NB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sd_q[NB].zero) begin
      packed_word0_o <= qstp_pkg::ZERO_WORD01;
      packed_word1_o <= qstp_pkg::ZERO_WORD01;
      packed_word2_o <= qstp_pkg::ZERO_WORD2;
    end else begin
      packed_word0_o <= {sd_q[NB].big_idx[0], code[0]};
      packed_word1_o <= {sd_q[NB].big_idx[1], code[1]};
      packed_word2_o <= {sd_q[NB].big_neg, code[2]};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/quaternion_smallest_three_pack_unit.sv =====
// Top level of the smallest-three quaternion packer (48-bit form).
// Depends on qstp_pkg, qstp_front, qstp_fifo and qstp_back.
//
// Channel   Direction  Handshake                Payload
// request   in         start_i high, busy_o low comp_x_i, comp_y_i, comp_z_i, comp_w_i
// result    out        valid_o, one cycle       packed_word0_o..packed_word2_o
//
// One request may be taken in every cycle. Each result passes in order through the
// input register, the queue, three multiply stages, fifteen stages of the root
// search (one code bit each) and the output register. The receiver cannot stall,
// so the back part never stops and busy_o stays low in normal running. Reset is
// asynchronous and clears every valid flag.
`default_nettype none
module quaternion_smallest_three_pack_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] comp_x_i,
  input  wire logic [31:0] comp_y_i,
  input  wire logic [31:0] comp_z_i,
  input  wire logic [31:0] comp_w_i,
  output logic             valid_o,
  output logic [15:0]      packed_word0_o,
  output logic [15:0]      packed_word1_o,
  output logic [15:0]      packed_word2_o
);

  // The front part registers the request, forms magnitudes and signs, and picks
  // the largest component (lowest index on ties) before handing it on.
  logic             push, pop, full;
  qstp_pkg::entry_t front_entry, head_entry;

  qstp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .comp_x_i (comp_x_i),
    .comp_y_i (comp_y_i),
    .comp_z_i (comp_z_i),
    .comp_w_i (comp_w_i),
    .full_i   (full),
    .busy_o   (busy_o),
    .push_o   (push),
    .entry_o  (front_entry)
  );

  // The queue decouples the two parts; the back part drains it every cycle.
  qstp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_o   (pop),
    .entry_o (head_entry)
  );

  // The back part finds each code exactly as the largest m with
  // m^2 2^32 Q <= (a K)^2, one bit per stage, then offsets, clamps and packs.
  qstp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_i          (pop),
    .entry_i        (head_entry),
    .valid_o        (valid_o),
    .packed_word0_o (packed_word0_o),
    .packed_word1_o (packed_word1_o),
    .packed_word2_o (packed_word2_o)
  );

endmodule
`default_nettype wire

// ===== rtl/qstp_checker.sv =====
// Port-level checks for the smallest-three quaternion packer, bound to the top.
// Depends on quaternion_smallest_three_pack_unit.
`default_nettype none
module qstp_assertions (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic [31:0] comp_x_i,
  input wire logic [31:0] comp_y_i,
  input wire logic [31:0] comp_z_i,
  input wire logic [31:0] comp_w_i,
  input wire logic        valid_o,
  input wire logic [15:0] packed_word0_o,
  input wire logic [15:0] packed_word1_o,
  input wire logic [15:0] packed_word2_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  // The back part never stalls, so the queue can never fill.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised although the back part never stalls");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##21 valid_o)
    else $error("request did not produce a result after 21 cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 21))
    else $error("result without a matching request");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && comp_x_i == 32'd0 && comp_y_i == 32'd0 && comp_z_i == 32'd0 &&
     comp_w_i == 32'd0) |-> ##21
    (packed_word0_o == 16'hBFFF && packed_word1_o == 16'hBFFF &&
     packed_word2_o == 16'h3FFF))
    else $error("zero quaternion not packed as the identity");

endmodule

bind quaternion_smallest_three_pack_unit qstp_assertions u_qstp_assertions (.*);
`default_nettype wire

// ===== tb/qstp_checker.sv =====
// Checker for the smallest-three quaternion packer: watches requests and results,
// predicts each packed triple and compares it as a whole. Depends on nothing.
module qstp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [31:0] comp_x_i,
  input  logic [31:0] comp_y_i,
  input  logic [31:0] comp_z_i,
  input  logic [31:0] comp_w_i,
  input  logic        valid_i,
  input  logic [15:0] word0_i,
  input  logic [15:0] word1_i,
  input  logic [15:0] word2_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] SCALE_K = 32'd1518407568;

  logic [47:0] packed_q[$];

  // Largest m with m^2 * 2^32 * sumsq <= a^2 * K^2, found one bit at a time.
  function automatic logic [14:0] magnitude_code(logic [31:0] a, logic [65:0] sumsq);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [14:0]  m;
    logic [14:0]  cand;
    rhs = 128'(a) * 128'(a) * 128'(SCALE_K) * 128'(SCALE_K);
    m = '0;
    for (int b = 14; b >= 0; b--) begin
      cand = m | (15'd1 << b);
      lhs = (128'(cand) * 128'(cand) * 128'(sumsq)) << 32;
      if (lhs <= rhs) m = cand;
    end
    return m;
  endfunction

  function automatic logic [47:0] pack_quaternion(logic [3:0][31:0] c);
    logic [31:0] mag [4];
    logic        neg [4];
    logic [65:0] sumsq;
    logic [14:0] codes [3];
    int          big;
    int          n;
    int          code;
    sumsq = '0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = c[i][31];
      mag[i] = neg[i] ? (~c[i] + 32'd1) : c[i];
      sumsq += 66'(mag[i]) * 66'(mag[i]);
    end
    if (sumsq == 0) return {16'h3FFF, 16'hBFFF, 16'hBFFF};
    big = 0;
    for (int i = 1; i < 4; i++) if (mag[i] > mag[big]) big = i;
    n = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != big) begin
        code = int'(magnitude_code(mag[i], sumsq));
        code = neg[i] ? 16383 - code : 16383 + code;
        if (code < 0) code = 0;
        if (code > 32767) code = 32767;
        codes[n] = code[14:0];
        n++;
      end
    end
    return {neg[big], codes[2], big[1], codes[1], big[0], codes[0]};
  endfunction

  logic [47:0] want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packed_q.delete();
      fail_count_o <= 0;
    end else begin
      if (start_i && !busy_i)
        packed_q.insert(packed_q.size(),
                        pack_quaternion({comp_w_i, comp_z_i, comp_y_i, comp_x_i}));
      if (valid_i) begin
        if (packed_q.size() == 0) begin
          $display("%0t: result with no request pending: %h %h %h", $time,
                   word0_i, word1_i, word2_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = packed_q.pop_front();
          if ({word2_i, word1_i, word0_i} !== want) begin
            $display("%0t: mismatch expected %h %h %h actual %h %h %h", $time,
                     want[15:0], want[31:16], want[47:32], word0_i, word1_i, word2_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = packed_q.size();
endmodule

// ===== tb/tb_quaternion_smallest_three_pack_unit.sv =====
// Testbench top for the smallest-three quaternion packer: drives requests with
// random gaps and gives the verdict. Depends on qstp_checker and the RTL top.
module tb_quaternion_smallest_three_pack_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 1900;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] comp_x_i = '0, comp_y_i = '0, comp_z_i = '0, comp_w_i = '0;
  logic        valid_o;
  logic [15:0] packed_word0_o, packed_word1_o, packed_word2_o;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  quaternion_smallest_three_pack_unit dut (.*);

  qstp_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o),
    .comp_x_i, .comp_y_i, .comp_z_i, .comp_w_i,
    .valid_i(valid_o), .word0_i(packed_word0_o), .word1_i(packed_word1_o),
    .word2_i(packed_word2_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // The watchdog counts cycles in which neither a request nor a result moves.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[quaternion_smallest_three_pack_unit] ERROR");
      $finish;
    end
  end

  // Presents one request from the falling edge and holds it until it is taken.
  task automatic send_request(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] w);
    comp_x_i <= x;
    comp_y_i <= y;
    comp_z_i <= z;
    comp_w_i <= w;
    start_i  <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Mostly back to back, sometimes short gaps, rarely long ones.
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Component picker: extremes, small values, exact ties and fully random words.
  function automatic logic [31:0] random_component();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(0, 8)) - 4);
      3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      4: return 32'h0100_0000;
      5: return 32'hFF00_0000;
      default: return $urandom;
    endcase
  endfunction

  logic [31:0] rnd_x, rnd_y, rnd_z, rnd_w;

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero length, each axis alone with one sign, ties and the most negative value.
    send_request(0, 0, 0, 0);
    send_request(32'h0100_0000, 0, 0, 0);
    send_request(0, 32'hFF00_0000, 0, 0);
    send_request(0, 0, 32'h0100_0000, 0);
    send_request(0, 0, 0, 32'hFF00_0000);
    send_request(32'h0080_0000, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000);
    send_request(32'hFF80_0000, 32'h0080_0000, 32'hFF80_0000, 32'h0080_0000);
    send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(1, 0, 0, 0);
    send_request(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1);
    send_request(0, 0, 32'h0100_0000, 32'h0100_0000);
    send_request(32'h00B5_04F3, 32'hFF4A_FB0D, 0, 0);
    send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      rnd_x = random_component();
      rnd_y = random_component();
      rnd_z = random_component();
      rnd_w = random_component();
      // Now and then copy one component into another to force magnitude ties.
      if ($urandom_range(0, 9) == 0) rnd_w = rnd_x;
      if ($urandom_range(0, 9) == 0) rnd_z = -rnd_y;
      if (i > 200 && i < 400) begin
        send_request(rnd_x, rnd_y, rnd_z, rnd_w);
      end else begin
        idle_gap();
        send_request(rnd_x, rnd_y, rnd_z, rnd_w);
      end
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[quaternion_smallest_three_pack_unit] OK");
    end else begin
      $display("[quaternion_smallest_three_pack_unit] ERROR");
    end
    $finish;
  end
endmodule
